@@ hw/rtl/drds_pkg.sv @@
// Shared types and constants for the display row diff SysEx sender.
`timescale 1ns / 1ps

package drds_pkg;

   // Request codes carried in the req_type field
   localparam logic REQ_CHAR       = 1'b0;
   localparam logic REQ_INVALIDATE = 1'b1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_DEVICE_TYPE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PROX_ENABLED = 1'b1;

   // Message bytes
   localparam logic [7:0] SYSEX_START   = 8'hF0;
   localparam logic [7:0] SYSEX_END     = 8'hF7;
   localparam logic [7:0] MFR_ZERO      = 8'h00;
   localparam logic [7:0] DEV_ID_66     = 8'h66;
   localparam logic [7:0] DEV_ID_67     = 8'h67;
   localparam logic [7:0] DEV_MODEL_14  = 8'h14;
   localparam logic [7:0] DEV_MODEL_15  = 8'h15;
   localparam logic [7:0] CMD_LOWER     = 8'h12;
   localparam logic [7:0] CMD_UPPER     = 8'h13;
   localparam logic [7:0] SHADOW_RESET  = 8'h01;
   localparam logic [7:0] ODD_ROW_OFFSET = 8'd56;

   // Byte positions inside one burst
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_START  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_MFR0   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_MFR1   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DEV1   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DEV2   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_CMD    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_OFFSET = 4'd6;
   localparam logic [STEP_W-1:0] STEP_CHAR   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_END    = 4'd8;

   typedef struct packed {
      logic       req_type;
      logic [1:0] row;
      logic [5:0] column;
      logic [7:0] char_code;
      logic       row_end;
      logic       display_active;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       burst_last;
   } rsp_item_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic                 data;
   } csr_write_type;

endpackage

@@ hw/rtl/drds_chan_if.sv @@
// Valid/ready channel carrying one payload item per transfer.
`timescale 1ns / 1ps

interface drds_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/display_row_diff_sysex_sender.sv @@
// Display row diff SysEx sender: shadow compare and message byte stream.
// A character transfer is registered into stage B before the byte emitter is loaded.
// Throughput: one character per cycle while runs continue and the emitter is free; a
// run opening costs its 8 output bytes (9 at row end), one per cycle while the result
// port is ready, set by the byte-wide result port. Shadow lives in a synchronous RAM
// (registered read) with per-entry valid bits. Reset (synchronous): all valid bits
// clear (shadow reads 0x01), run closed, CSRs zero; invalidate clears the valid bits.
`timescale 1ns / 1ps

module display_row_diff_sysex_sender #(
   parameter int ROWS      = 4,
   parameter int ROW_CHARS = 56
) (
   input logic        clock,
   input logic        reset,
   drds_chan_if.sink   req_ch,
   drds_chan_if.source rsp_ch,
   drds_chan_if.sink   csr_ch
);
   import drds_pkg::*;

   localparam int DEPTH = ROWS * ROW_CHARS;
   localparam int AW    = $clog2(DEPTH);

   req_item_type  a_item;
   csr_write_type csr_wr;

   // Configuration
   logic device_type_ff, prox_enabled_ff;

   // Shadow store
   logic [7:0]       shadow_mem [DEPTH];
   logic [DEPTH-1:0] shadow_vld_ff;
   logic [7:0]       rd_data_ff;

   // Stage A (address) and stage B (compare)
   logic          a_go, a_in_range;
   logic [AW-1:0] a_addr;
   logic          b_valid_ff, b_in_range_ff;
   req_item_type  b_item_ff;
   logic [AW-1:0] b_addr_ff;
   logic          fwd_hit_ff;
   logic [7:0]    fwd_data_ff;
   logic          run_open_ff, run_open_in;

   logic       b_go, b_char, b_inv, b_load;
   logic [7:0] b_old;
   logic       b_differ, b_emit, b_hdr, b_ch_en, b_f7;

   // Byte emitter
   logic              em_busy_ff;
   logic [STEP_W-1:0] em_step_ff, em_last_step_ff;
   logic [7:0]        em_dev1_ff, em_dev2_ff, em_cmd_ff, em_off_ff, em_char_ff;
   logic              em_free, em_done;
   logic [7:0]        em_byte;
   rsp_item_type      rsp_item;

   assign a_item = req_ch.payload;
   assign csr_wr = csr_ch.payload;

   // ---------------- configuration ----------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_type_ff  <= 1'b0;
         prox_enabled_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_wr.index)
            REG_DEVICE_TYPE:  device_type_ff  <= csr_wr.data;
            REG_PROX_ENABLED: prox_enabled_ff <= csr_wr.data;
            default: ;
         endcase
      end
   end

   // ---------------- stage A: address and read ----------------
   assign a_in_range = (int'(a_item.row) < ROWS) && (int'(a_item.column) < ROW_CHARS);
   assign a_addr     = AW'(int'(a_item.row) * ROW_CHARS + int'(a_item.column));
   assign req_ch.ready = !b_valid_ff || b_go;
   assign a_go         = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (a_go && a_in_range) begin
         rd_data_ff <= shadow_mem[a_addr];
      end
      if (b_go && b_char) begin
         shadow_mem[b_addr_ff] <= b_item_ff.char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_go) begin
         b_valid_ff <= 1'b1;
      end else if (b_go) begin
         b_valid_ff <= 1'b0;
      end
   end

   // Capture the write landing in the same cycle as the read: the RAM returns old data
   always_ff @(posedge clock) begin
      if (a_go) begin
         b_item_ff     <= a_item;
         b_addr_ff     <= a_addr;
         b_in_range_ff <= a_in_range;
         fwd_hit_ff    <= b_go && b_char && (b_addr_ff == a_addr);
         fwd_data_ff   <= b_item_ff.char_code;
      end
   end

   // ---------------- stage B: compare and decide ----------------
   assign b_inv  = b_valid_ff && (b_item_ff.req_type == REQ_INVALIDATE);
   assign b_char = b_valid_ff && (b_item_ff.req_type == REQ_CHAR) &&
                   b_item_ff.display_active && b_in_range_ff;

   always_comb begin
      if (!shadow_vld_ff[b_addr_ff]) begin
         b_old = SHADOW_RESET;
      end else if (fwd_hit_ff) begin
         b_old = fwd_data_ff;
      end else begin
         b_old = rd_data_ff;
      end
   end

   assign b_differ = (b_old != b_item_ff.char_code);
   assign b_emit   = !(b_item_ff.row[1] && !prox_enabled_ff);
   assign b_hdr    = b_differ && !run_open_ff && b_emit;
   assign b_ch_en  = b_differ && b_emit;
   assign b_f7     = b_emit && (b_differ ? b_item_ff.row_end : run_open_ff);
   assign b_load   = b_char && (b_ch_en || b_f7);
   assign b_go     = b_valid_ff && (!b_load || em_free);

   always_comb begin
      run_open_in = run_open_ff;
      if (b_inv) begin
         run_open_in = 1'b0;
      end else if (b_char) begin
         run_open_in = b_differ && !b_item_ff.row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff   <= 1'b0;
         shadow_vld_ff <= '0;
      end else if (b_go) begin
         run_open_ff <= run_open_in;
         if (b_inv) begin
            shadow_vld_ff <= '0;
         end else if (b_char) begin
            shadow_vld_ff[b_addr_ff] <= 1'b1;
         end
      end
   end

   // ---------------- byte emitter ----------------
   assign em_done = rsp_ch.ready && (em_step_ff == em_last_step_ff);
   assign em_free = !em_busy_ff || em_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         em_busy_ff      <= 1'b0;
         em_step_ff      <= STEP_START;
         em_last_step_ff <= STEP_END;
      end else if (b_go && b_load) begin
         em_busy_ff      <= 1'b1;
         em_step_ff      <= b_hdr ? STEP_START : (b_ch_en ? STEP_CHAR : STEP_END);
         em_last_step_ff <= b_f7 ? STEP_END : STEP_CHAR;
      end else if (em_busy_ff && em_done) begin
         em_busy_ff <= 1'b0;
      end else if (em_busy_ff && rsp_ch.ready) begin
         // advance to the next byte of the burst
         em_step_ff <= em_step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (b_go && b_load) begin
         em_dev1_ff <= (!device_type_ff && b_item_ff.row[1]) ? DEV_ID_67 : DEV_ID_66;
         em_dev2_ff <= (device_type_ff || b_item_ff.row[1]) ? DEV_MODEL_15 : DEV_MODEL_14;
         em_cmd_ff  <= b_item_ff.row[1] ? CMD_UPPER : CMD_LOWER;
         em_off_ff  <= {2'b00, b_item_ff.column} + (b_item_ff.row[0] ? ODD_ROW_OFFSET : 8'd0);
         em_char_ff <= b_item_ff.char_code;
      end
   end

   always_comb begin
      case (em_step_ff)
         STEP_START:  em_byte = SYSEX_START;
         STEP_MFR0:   em_byte = MFR_ZERO;
         STEP_MFR1:   em_byte = MFR_ZERO;
         STEP_DEV1:   em_byte = em_dev1_ff;
         STEP_DEV2:   em_byte = em_dev2_ff;
         STEP_CMD:    em_byte = em_cmd_ff;
         STEP_OFFSET: em_byte = em_off_ff;
         STEP_CHAR:   em_byte = em_char_ff;
         STEP_END:    em_byte = SYSEX_END;
         default:     em_byte = SYSEX_END;
      endcase
   end

   assign rsp_item.out_byte   = em_byte;
   assign rsp_item.burst_last = (em_step_ff == em_last_step_ff);
   assign rsp_ch.valid        = em_busy_ff;
   assign rsp_ch.payload      = rsp_item;

   // ---------------- assertions ----------------
   a_step_in_burst: assert property (@(posedge clock) disable iff (reset)
      em_busy_ff |-> (em_step_ff <= em_last_step_ff))
      else $error("emitter step past last byte of burst");

   a_inv_clears: assert property (@(posedge clock) disable iff (reset)
      (b_go && b_inv) |=> (shadow_vld_ff == '0))
      else $error("invalidate left shadow entries valid");

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      (b_go && b_char) |=> shadow_vld_ff[$past(b_addr_ff)])
      else $error("written shadow entry not marked valid");

   a_row_end_closes: assert property (@(posedge clock) disable iff (reset)
      (b_go && b_char && b_item_ff.row_end) |=> !run_open_ff)
      else $error("run still open after row end");

endmodule

@@ test/tb_display_row_diff_sysex_sender.sv @@
// Self-checking testbench for the display row diff SysEx sender.
`timescale 1ns / 1ps

module tb_display_row_diff_sysex_sender;
   import drds_pkg::*;

   localparam int ROW_COUNT = 4;
   localparam int ROW_LEN   = 56;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_CHARS = 115;

   logic clock;
   logic reset;

   drds_chan_if #(.payload_type(req_item_type))  req_if ();
   drds_chan_if #(.payload_type(rsp_item_type))  rsp_if ();
   drds_chan_if #(.payload_type(csr_write_type)) csr_if ();

   display_row_diff_sysex_sender #(
      .ROWS      (ROW_COUNT),
      .ROW_CHARS (ROW_LEN)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Predicted display state and register copies
   logic [7:0]   disp_shadow [ROW_COUNT*ROW_LEN];
   logic         run_active;
   logic         dev_type_cfg;
   logic         prox_cfg;
   rsp_item_type expected_bytes [$];

   // Shadow as seen by the stimulus generator, ahead of the predictor by every queued item
   logic [7:0]   plan_shadow [ROW_COUNT*ROW_LEN];
   req_item_type req_pending [$];

   int unsigned req_sent;
   int unsigned req_taken;
   int unsigned bytes_seen;
   int unsigned mismatches;
   int          burst_left;
   int          gap_left;
   bit          sender_gaps;
   bit          rsp_stalls;
   logic [31:0] stall_word;
   int          stall_pos;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_display_row_diff_sysex_sender: FAIL");
      $finish;
   end

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void predict_sysex(req_item_type it);
      rsp_item_type burst [$];
      logic [7:0]   dev_id;
      logic [7:0]   dev_model;
      logic [7:0]   offset;
      int unsigned  slot;
      bit           differ;
      bit           emit;
      if (it.req_type == REQ_INVALIDATE) begin
         foreach (disp_shadow[i]) disp_shadow[i] = SHADOW_RESET;
         run_active = 1'b0;
         return;
      end
      if (!it.display_active || it.row >= ROW_COUNT || it.column >= ROW_LEN) return;
      slot   = it.row * ROW_LEN + it.column;
      differ = disp_shadow[slot] != it.char_code;
      emit   = !(it.row > 1 && !prox_cfg);
      if (differ) begin
         if (!run_active) begin
            if (dev_type_cfg) begin
               dev_id = DEV_ID_66;
               dev_model = DEV_MODEL_15;
            end else if (it.row <= 1) begin
               dev_id = DEV_ID_66;
               dev_model = DEV_MODEL_14;
            end else begin
               dev_id = DEV_ID_67;
               dev_model = DEV_MODEL_15;
            end
            offset = 8'(it.column) + (it.row[0] ? ODD_ROW_OFFSET : 8'd0);
            if (emit) begin
               burst.push_back('{SYSEX_START, 1'b0});
               burst.push_back('{MFR_ZERO, 1'b0});
               burst.push_back('{MFR_ZERO, 1'b0});
               burst.push_back('{dev_id, 1'b0});
               burst.push_back('{dev_model, 1'b0});
               burst.push_back('{(it.row > 1) ? CMD_UPPER : CMD_LOWER, 1'b0});
               burst.push_back('{offset, 1'b0});
            end
            run_active = 1'b1;
         end
         if (emit) burst.push_back('{it.char_code, 1'b0});
         if (it.row_end) begin
            if (emit) burst.push_back('{SYSEX_END, 1'b0});
            run_active = 1'b0;
         end
      end else if (run_active) begin
         if (emit) burst.push_back('{SYSEX_END, 1'b0});
         run_active = 1'b0;
      end
      disp_shadow[slot] = it.char_code;
      if (burst.size() > 0) burst[burst.size()-1].burst_last = 1'b1;
      foreach (burst[i]) expected_bytes.push_back(burst[i]);
   endfunction

   // Queue one item; returns 1 if the block acts on it
   function automatic bit queue_item(logic req, logic [1:0] row, logic [5:0] col,
                                     logic [7:0] ch, logic last, logic active);
      req_item_type it;
      bit           acted;
      it = '{req, row, col, ch, last, active};
      acted = 1'b0;
      if (req == REQ_INVALIDATE) begin
         foreach (plan_shadow[i]) plan_shadow[i] = SHADOW_RESET;
         acted = 1'b1;
      end else if (active && row < ROW_COUNT && col < ROW_LEN) begin
         plan_shadow[row*ROW_LEN + col] = ch;
         acted = 1'b1;
      end
      req_pending.push_back(it);
      return acted;
   endfunction

   // One row of new text: alternating stretches of changed and unchanged characters
   function automatic int queue_row_text();
      int         row;
      int         first;
      int         len;
      int         acted;
      bit         changing;
      bit         last;
      logic [7:0] ch;
      row   = $urandom_range(0, ROW_COUNT-1);
      first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ROW_LEN-2) : 0;
      len   = $urandom_range(1, ROW_LEN - first);
      if ($urandom_range(0, 2) == 0 && len > 12) len = $urandom_range(1, 12);
      changing = $urandom_range(0, 1);
      acted = 0;
      for (int c = first; c < first + len; c++) begin
         if ($urandom_range(0, 4) == 0) changing = !changing;
         ch = plan_shadow[row*ROW_LEN + c];
         if (changing) ch = ch ^ 8'($urandom_range(1, 255));
         // occasionally drop the row end marker
         last = (c == first + len - 1) && ($urandom_range(0, 9) != 0);
         acted += queue_item(REQ_CHAR, 2'(row), 6'(c), ch, last, 1'b1);
      end
      return acted;
   endfunction

   function automatic int queue_noise();
      logic req;
      req = ($urandom_range(0, 39) == 0) ? REQ_INVALIDATE : REQ_CHAR;
      return queue_item(req, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                        8'($urandom), 1'($urandom), $urandom_range(0, 3) != 0);
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic value);
      @(negedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= '{idx, value};
      do @(posedge clock); while (!csr_if.ready);
      if (idx == REG_DEVICE_TYPE) dev_type_cfg = value;
      else if (idx == REG_PROX_ENABLED) prox_cfg = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Wait until all queued text is taken and every expected byte has arrived
   task automatic drain();
      int quiet;
      quiet = 0;
      while (quiet < SETTLE_CYCLES) begin
         @(negedge clock);
         if (req_pending.size() == 0 && req_taken == req_sent && expected_bytes.size() == 0)
            quiet++;
         else
            quiet = 0;
      end
   endtask

   // Sender: bursts of transfers separated by random gaps when sender_gaps is set
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_taken != req_sent) begin
         // hold until the current item transfers
      end else if (gap_left > 0) begin
         gap_left--;
         req_if.valid <= 1'b0;
      end else if (req_pending.size() > 0) begin
         req_if.payload <= req_pending.pop_front();
         req_if.valid   <= 1'b1;
         req_sent++;
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = sender_gaps ? $urandom_range(0, 6) : 0;
         end
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // Receiver: with rsp_stalls set, stall on a random bit pattern, sometimes a fully ready stretch
   always @(negedge clock) begin
      if (stall_pos == 0) begin
         stall_word = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
      end
      rsp_if.ready <= !rsp_stalls || stall_word[stall_pos];
      stall_pos = (stall_pos + 1) % 32;
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            bytes_seen++;
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b",
                                         rsp_if.payload.out_byte, rsp_if.payload.burst_last));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_if.payload.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_if.payload.out_byte, want.out_byte));
               if (rsp_if.payload.burst_last !== want.burst_last)
                  report_mismatch($sformatf("burst_last %0b, expected %0b (byte %02h)",
                                            rsp_if.payload.burst_last, want.burst_last,
                                            want.out_byte));
            end
         end
         if (req_if.valid && req_if.ready) begin
            req_taken++;
            predict_sysex(req_if.payload);
         end
      end
   end

   initial begin
      int counted;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      foreach (disp_shadow[i]) disp_shadow[i] = SHADOW_RESET;
      foreach (plan_shadow[i]) plan_shadow[i] = SHADOW_RESET;
      run_active   = 1'b0;
      dev_type_cfg = 1'b0;
      prox_cfg     = 1'b0;
      req_sent     = 0;
      req_taken    = 0;
      bytes_seen   = 0;
      mismatches   = 0;
      burst_left   = 1;
      gap_left     = 0;
      sender_gaps  = 1'b0;
      rsp_stalls   = 1'b0;
      stall_word   = '1;
      stall_pos    = 0;
      counted      = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: main unit, proximity on
      write_csr(REG_DEVICE_TYPE, 1'b0);
      write_csr(REG_PROX_ENABLED, 1'b1);
      @(posedge clock);
      counted += queue_item(REQ_CHAR, 2'd0, 6'd0, 8'h41, 1'b0, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd0, 6'd1, 8'h42, 1'b0, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd0, 6'd2, SHADOW_RESET, 1'b0, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd1, 6'd55, 8'hFF, 1'b1, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd2, 6'd0, 8'h00, 1'b1, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd3, 6'd10, 8'h80, 1'b0, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd3, 6'd11, 8'h7F, 1'b0, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd3, 6'd12, SHADOW_RESET, 1'b0, 1'b1);
      // out of range columns and an inactive display: all dropped
      counted += queue_item(REQ_CHAR, 2'd0, 6'd56, 8'h55, 1'b0, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd3, 6'd63, 8'hAA, 1'b1, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd0, 6'd3, 8'h7E, 1'b0, 1'b0);
      // row change keeps the open run going
      counted += queue_item(REQ_CHAR, 2'd0, 6'd5, 8'h78, 1'b0, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd2, 6'd6, 8'h79, 1'b0, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd2, 6'd7, SHADOW_RESET, 1'b0, 1'b1);
      // invalidate inside a run, with the display flag low
      counted += queue_item(REQ_CHAR, 2'd1, 6'd3, 8'h7A, 1'b0, 1'b1);
      counted += queue_item(REQ_INVALIDATE, 2'd3, 6'd63, 8'hFF, 1'b1, 1'b0);
      counted += queue_item(REQ_CHAR, 2'd1, 6'd3, 8'h7A, 1'b1, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd0, 6'd0, SHADOW_RESET, 1'b0, 1'b1);
      drain();

      // Directed: extender, proximity off; runs that lose their header or F7
      write_csr(REG_DEVICE_TYPE, 1'b1);
      write_csr(REG_PROX_ENABLED, 1'b0);
      @(posedge clock);
      counted += queue_item(REQ_CHAR, 2'd0, 6'd0, 8'h20, 1'b0, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd0, 6'd1, 8'h21, 1'b1, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd2, 6'd20, 8'h33, 1'b0, 1'b1);
      drain();
      write_csr(REG_PROX_ENABLED, 1'b1);
      @(posedge clock);
      counted += queue_item(REQ_CHAR, 2'd2, 6'd21, 8'h34, 1'b1, 1'b1);
      counted += queue_item(REQ_CHAR, 2'd3, 6'd30, 8'h35, 1'b0, 1'b1);
      drain();
      write_csr(REG_PROX_ENABLED, 1'b0);
      @(posedge clock);
      counted += queue_item(REQ_CHAR, 2'd3, 6'd31, SHADOW_RESET, 1'b0, 1'b1);
      drain();

      // Random: every register setting; result stalls from the second phase, sender gaps from the third
      for (int p = 0; p < 4; p++) begin
         write_csr(REG_DEVICE_TYPE, p[0]);
         write_csr(REG_PROX_ENABLED, p[1]);
         rsp_stalls  = (p != 0);
         sender_gaps = (p >= 2);
         @(posedge clock);
         counted = 0;
         while (counted < PHASE_CHARS) begin
            if ($urandom_range(0, 9) < 8) counted += queue_row_text();
            else counted += queue_noise();
         end
         drain();
      end

      $display("Run covered %0d character transfers and %0d message bytes", req_taken,
               bytes_seen);
      $display("across both device types and both proximity settings");
      if (mismatches == 0) begin
         $display("tb_display_row_diff_sysex_sender: PASS");
      end else begin
         $display("tb_display_row_diff_sysex_sender: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/drds_pkg.sv
hw/rtl/drds_chan_if.sv
hw/rtl/display_row_diff_sysex_sender.sv
test/tb_display_row_diff_sysex_sender.sv
